/* rtl/lz78e_pkg.sv */
package lz78e_pkg;

    localparam int IDX_W = 12;
    localparam int BYTE_W = 8;
    localparam int ENT_W = IDX_W + BYTE_W;

    typedef struct packed {
        logic             shift;
        logic             load;
        logic [ENT_W-1:0] data;
    } t_ring_ctl;

endpackage

/* rtl/lz78_stream_encoder.sv */
// Each beat is scanned at the ring head; a miss, or a hit on the last beat, then loads the output register.
// A hit ends the scan at the matching entry; a miss rotates the whole ring of cells once.
// A new beat is taken only in idle, after the scan and any token emit for the last beat are done;
// the single compare at the ring head sets the scan, a stalled output register holds the emit.
// Reset: synchronous, active low; clears match, head and step, sets entry counter to 1, limit to 4095, handshake idle.
// Dictionary cells have no reset and no clearing pass; only entries written since are compared.
module lz78_stream_encoder #(
    parameter int DICT_ENTRIES = 4096
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [lz78e_pkg::IDX_W-1:0]  i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [lz78e_pkg::BYTE_W-1:0] i_in_byte,
    input  logic                         i_end_of_stream,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [lz78e_pkg::IDX_W-1:0]  o_prefix_index,
    output logic [lz78e_pkg::BYTE_W-1:0] o_literal,
    output logic                         o_has_literal,
    output logic                         o_dict_full
);
    import lz78e_pkg::*;

    localparam int IW = $clog2(DICT_ENTRIES);
    localparam int EW = (IW > IDX_W) ? IW : IDX_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_limit, n_limit;
    logic [IDX_W-1:0]  r_next, n_next;
    logic [IDX_W-1:0]  r_match, n_match;
    logic [ENT_W-1:0]  r_key, n_key;
    logic              r_last, n_last;
    logic [IW-1:0]     r_head, n_head;
    logic [IW-1:0]     r_step, n_step;
    logic [IDX_W-1:0]  r_res_idx, n_res_idx;
    logic [BYTE_W-1:0] r_res_lit, n_res_lit;
    logic              r_res_has, n_res_has;
    logic              r_res_full, n_res_full;
    logic              r_out_vld, n_out_vld;
    logic [IDX_W-1:0]  r_out_idx, n_out_idx;
    logic [BYTE_W-1:0] r_out_lit, n_out_lit;
    logic              r_out_has, n_out_has;
    logic              r_out_full, n_out_full;

    t_ring_ctl         w_ctl;
    logic [ENT_W-1:0]  w_head_data;
    logic [IDX_W-1:0]  w_top12;
    logic [EW-1:0]     w_top;
    logic [EW-1:0]     w_alloc;
    logic [EW-1:0]     w_head_ext;
    logic              w_full;
    logic              w_hit;
    logic              w_write;
    logic              w_step_last;

    lz78e_ring #(
        .DICT_ENTRIES (DICT_ENTRIES)
    ) u_ring (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .o_head (w_head_data)
    );

    always_comb begin
        w_top12 = (r_next == '0) ? '1 : r_next - 1'b1;
        w_top = (EW'(w_top12) > EW'(DICT_ENTRIES - 1)) ? EW'(DICT_ENTRIES - 1) : EW'(w_top12);
        w_alloc = (EW'(r_limit) > EW'(DICT_ENTRIES - 1)) ? EW'(DICT_ENTRIES - 1) : EW'(r_limit);
        w_full = (r_next == '0) || (EW'(r_next) > w_alloc);
        w_head_ext = EW'(r_head);
        w_hit = (w_head_ext != '0) && (w_head_ext <= w_top) && (w_head_data == r_key);
        w_write = (w_head_ext == EW'(r_next)) && !w_full;
        w_step_last = (r_step == IW'(DICT_ENTRIES - 1));
    end

    always_comb begin
        n_state    = r_state;
        n_limit    = r_limit;
        n_next     = r_next;
        n_match    = r_match;
        n_key      = r_key;
        n_last     = r_last;
        n_head     = r_head;
        n_step     = r_step;
        n_res_idx  = r_res_idx;
        n_res_lit  = r_res_lit;
        n_res_has  = r_res_has;
        n_res_full = r_res_full;
        n_out_vld  = r_out_vld;
        n_out_idx  = r_out_idx;
        n_out_lit  = r_out_lit;
        n_out_has  = r_out_has;
        n_out_full = r_out_full;
        w_ctl.shift = 1'b0;
        w_ctl.load  = 1'b0;
        w_ctl.data  = r_key;

        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end
        if (i_cfg_we) begin
            n_limit = i_cfg_data;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_key   = {r_match, i_in_byte};
                    n_last  = i_end_of_stream;
                    n_step  = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_hit) begin
                    n_match    = w_head_ext[IDX_W-1:0];
                    n_res_idx  = w_head_ext[IDX_W-1:0];
                    n_res_lit  = '0;
                    n_res_has  = 1'b0;
                    n_res_full = 1'b0;
                    if (r_last) begin
                        n_match = '0;
                        n_next  = IDX_W'(1);
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    w_ctl.shift = 1'b1;
                    w_ctl.load  = w_write;
                    n_head = (r_head == IW'(DICT_ENTRIES - 1)) ? '0 : r_head + 1'b1;
                    n_step = r_step + 1'b1;
                    if (w_step_last) begin
                        n_res_idx  = r_key[ENT_W-1:BYTE_W];
                        n_res_lit  = r_key[BYTE_W-1:0];
                        n_res_has  = 1'b1;
                        n_res_full = w_full;
                        if (!w_full) begin
                            n_next = r_next + 1'b1;
                        end
                        n_match = '0;
                        if (r_last) begin
                            n_next = IDX_W'(1);
                        end
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out_vld  = 1'b1;
                    n_out_idx  = r_res_idx;
                    n_out_lit  = r_res_lit;
                    n_out_has  = r_res_has;
                    n_out_full = r_res_full;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_limit   <= IDX_W'(4095);
            r_next    <= IDX_W'(1);
            r_match   <= '0;
            r_head    <= '0;
            r_step    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_limit   <= n_limit;
            r_next    <= n_next;
            r_match   <= n_match;
            r_head    <= n_head;
            r_step    <= n_step;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_last     <= n_last;
        r_res_idx  <= n_res_idx;
        r_res_lit  <= n_res_lit;
        r_res_has  <= n_res_has;
        r_res_full <= n_res_full;
        r_out_idx  <= n_out_idx;
        r_out_lit  <= n_out_lit;
        r_out_has  <= n_out_has;
        r_out_full <= n_out_full;
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_vld;
    assign o_prefix_index = r_out_idx;
    assign o_literal      = r_out_lit;
    assign o_has_literal  = r_out_has;
    assign o_dict_full    = r_out_full;

endmodule

/* rtl/lz78e_cell.sv */
module lz78e_cell (
    input  logic                       i_clk,
    input  logic                       i_shift,
    input  logic [lz78e_pkg::ENT_W-1:0] i_data,
    output logic [lz78e_pkg::ENT_W-1:0] o_data
);
    import lz78e_pkg::*;

    logic [ENT_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;

endmodule

/* rtl/lz78e_ring.sv */
module lz78e_ring #(
    parameter int DICT_ENTRIES = 4096
) (
    input  logic                        i_clk,
    input  lz78e_pkg::t_ring_ctl        i_ctl,
    output logic [lz78e_pkg::ENT_W-1:0] o_head
);
    import lz78e_pkg::*;

    logic [ENT_W-1:0] w_cell [DICT_ENTRIES];

    genvar g;
    generate
        for (g = 0; g < DICT_ENTRIES; g++) begin : g_cell
            logic [ENT_W-1:0] w_in;
            if (g == DICT_ENTRIES - 1) begin : g_tail
                assign w_in = i_ctl.load ? i_ctl.data : w_cell[0];
            end else begin : g_body
                assign w_in = w_cell[g+1];
            end
            lz78e_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (i_ctl.shift),
                .i_data  (w_in),
                .o_data  (w_cell[g])
            );
        end
    endgenerate

    assign o_head = w_cell[0];

endmodule
